// File: src/assert_macros.svh
// Assertion helpers; the enclosing module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_AT(lbl, !(cond), msg)

`endif

// File: src/vlbp_pkg.sv
package vlbp_pkg;

  localparam int MaxFieldBits = 32;
  localparam int ValueBits    = 32;
  // Longest append that is carried out; longer counts are dropped.
  localparam int CountLimit   = (MaxFieldBits < ValueBits) ? MaxFieldBits : ValueBits;
  // Pending bits plus one full field.
  localparam int StreamBits   = ValueBits + 8;
  localparam int CmdFifoDepth = 2;

  typedef enum logic {
    KindAppend = 1'b0,
    KindFlush  = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 kind;
    logic [ValueBits-1:0] value;
    logic [5:0]           bit_count;
    logic                 fill_ones;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Byte job for the back end: the low nbits of bits, oldest bit highest.
  typedef struct packed {
    logic [StreamBits-1:0] bits;
    logic [5:0]            nbits;
  } cmd_t;

  function automatic logic [7:0] mirror_byte(input logic [7:0] b);
    logic [7:0] t;
    t = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
    t = ((t & 8'hCC) >> 2) | ((t & 8'h33) << 2);
    t = ((t & 8'hAA) >> 1) | ((t & 8'h55) << 1);
    return t;
  endfunction

endpackage

// File: src/variable_length_bit_packer.sv
// Path: with the back end idle, the first byte of an item reaches result_o through the
// command queue, the job register and the output register; further bytes of the item
// follow one per cycle while each is popped. Throughput: one result byte per cycle while
// results are popped; an item emits up to 4 bytes, and later items queue meanwhile.
// Reset (rst_ni low, asynchronous): partial byte cleared, command queue and
// output emptied, lsb_first_q cleared to MSB-first.
module variable_length_bit_packer import vlbp_pkg::*; #(
  parameter int CmdDepth = CmdFifoDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t result_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic lsb_first_q;
  logic accept;
  logic cmd_push, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_out;

  assign accept = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsb_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      lsb_first_q <= cfg_wdata_i;
    end
  end

  vlbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  vlbp_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_out)
  );

  vlbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lsb_first_i (lsb_first_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// File: src/vlbp_front.sv
module vlbp_front import vlbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  logic [7:0]            part_q, part_d;
  logic [2:0]            pend_q, pend_d;
  logic [ValueBits-1:0]  vmask;
  logic [StreamBits-1:0] stream;
  logic [5:0]            nbits;
  logic [3:0]            room;
  logic [7:0]            padded;
  logic                  too_long;

  always_comb begin
    vmask    = (item_i.bit_count >= 6'(ValueBits)) ? '1 :
               ~({ValueBits{1'b1}} << item_i.bit_count);
    stream   = ({{(StreamBits-8){1'b0}}, part_q} << item_i.bit_count) |
               {8'b0, item_i.value & vmask};
    nbits    = {3'b0, pend_q} + item_i.bit_count;
    too_long = item_i.bit_count > 6'(CountLimit);
    room     = 4'd8 - {1'b0, pend_q};
    padded   = part_q << room;
    if (item_i.fill_ones) begin
      padded = padded | ~(8'hFF << room);
    end
  end

  always_comb begin
    part_d     = part_q;
    pend_d     = pend_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{bits: stream, nbits: nbits};
    if (accept_i) begin
      if (item_i.kind == KindFlush) begin
        // pad the pending bits on the right and emit one byte if any bits are pending
        cmd_o      = '{bits: {{(StreamBits-8){1'b0}}, padded}, nbits: 6'd8};
        cmd_push_o = (pend_q != 3'd0);
        part_d     = '0;
        pend_d     = '0;
      end else if (!too_long) begin
        cmd_push_o = (nbits[5:3] != 3'd0);
        pend_d     = nbits[2:0];
        part_d     = stream[7:0] & ~(8'hFF << nbits[2:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      pend_q <= '0;
    end else begin
      part_q <= part_d;
      pend_q <= pend_d;
    end
  end

endmodule

// File: src/vlbp_cmd_fifo.sv
`include "assert_macros.svh"

module vlbp_cmd_fifo import vlbp_pkg::*; #(
  parameter int Depth = CmdFifoDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t rdata_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEVER(cmd_fifo_overflow, push_i && full_o, "command queue overflow")
  `ASSERT_NEVER(cmd_fifo_underflow, pop_i && empty_o, "command queue underflow")

endmodule

// File: src/vlbp_back.sv
`include "assert_macros.svh"

module vlbp_back import vlbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      lsb_first_i,
  input  logic      cmd_empty_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t result_o
);

  logic      busy_q, busy_d;
  cmd_t      cur_q, cur_d;
  logic      oval_q, oval_d;
  out_item_t res_q, res_d;
  logic      advance, done, taken;
  logic [5:0] shamt;
  logic [7:0] cur_byte;

  assign taken    = oval_q && pop_i;
  assign advance  = busy_q && (!oval_q || taken);
  assign done     = advance && (cur_q.nbits < 6'd16);
  assign cmd_pop_o = (!busy_q || done) && !cmd_empty_i;
  assign shamt    = cur_q.nbits - 6'd8;
  assign cur_byte = 8'(cur_q.bits >> shamt);

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    if (advance) begin
      cur_d.nbits = shamt;
    end
    if (cmd_pop_o) begin
      busy_d = 1'b1;
      cur_d  = cmd_i;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    oval_d = oval_q;
    res_d  = res_q;
    if (advance) begin
      oval_d         = 1'b1;
      res_d.out_byte = lsb_first_i ? mirror_byte(cur_byte) : cur_byte;
      res_d.last     = (cur_q.nbits < 6'd16);
    end else if (taken) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
  end

  assign empty_o  = !oval_q;
  assign result_o = res_q;

  `ASSERT_AT(back_job_has_byte, busy_q |-> (cur_q.nbits >= 6'd8), "job without full byte")
  `ASSERT_AT(back_result_held, (oval_q && !pop_i) |=> (oval_q && $stable(res_q)),
             "result dropped before transfer")

endmodule
